### hdl/text_console_cursor_controller_defines.svh
// Assertion helpers used by the checker file.
// Each macro expects clk_i and rst_ni to be visible where it is used.
`ifndef TEXT_CONSOLE_CURSOR_CONTROLLER_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROLLER_DEFINES_SVH

// Same-cycle implication, switched off while reset is active.
`define TCCC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("console cursor check failed");

// Next-cycle implication, switched off while reset is active.
`define TCCC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("console cursor check failed");

`endif

### hdl/tccc_pkg.sv
package tccc_pkg;

  localparam int DEF_MAX_COLUMNS   = 256;
  localparam int DEF_MAX_TEXT_ROWS = 128;
  localparam int DEF_GLYPH_HEIGHT  = 16;

  // Total font size in bytes; divided by the glyph height it gives the glyph count.
  localparam int FONT_BYTES = 3904;
  // Cursor state can address at most this many columns and rows.
  localparam int COL_STATE_LIMIT = 256;
  localparam int ROW_STATE_LIMIT = 128;

  localparam logic [7:0] CHAR_LF       = 8'd10;
  localparam logic [7:0] CHAR_CR       = 8'd13;
  localparam logic [7:0] CHAR_TAB      = 8'd9;
  localparam logic [7:0] GLYPH_UNKNOWN = 8'd63;
  localparam logic [8:0] TAB_STEP      = 9'd4;

  localparam logic [8:0]  COLUMNS_RESET = 9'd128;
  localparam logic [7:0]  ROWS_RESET    = 8'd48;
  localparam logic [31:0] FORE_RESET    = 32'h00FF_FFFF;
  localparam logic [31:0] BACK_RESET    = 32'h0000_0000;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int TDATA_IN_W  = 8;
  localparam int TDATA_OUT_W = 88;

  // Result queue; a byte writes up to two entries.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLUMNS    = 2'd0,
    CFG_ROWS       = 2'd1,
    CFG_FORE_COLOR = 2'd2,
    CFG_BACK_COLOR = 2'd3
  } cfg_idx_e;

  typedef enum logic {
    CMD_DRAW   = 1'b0,
    CMD_SCROLL = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  glyph_code;
    logic [7:0]  cell_column;
    logic [6:0]  cell_row;
    logic [31:0] ink_color;
    logic [31:0] paper_color;
    logic        last;
  } result_t;

  // What one accepted byte hands to the queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } push_t;

endpackage

### hdl/tccc_cursor.sv
module tccc_cursor #(
  parameter int MAX_COLUMNS   = tccc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_TEXT_ROWS = tccc_pkg::DEF_MAX_TEXT_ROWS,
  parameter int GLYPH_HEIGHT  = tccc_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [tccc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [tccc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                             accept_i,
  input  logic [7:0]                       char_byte_i,
  output tccc_pkg::push_t                  push_o
);
  import tccc_pkg::*;

  localparam int COL_LIM =
    (MAX_COLUMNS < COL_STATE_LIMIT) ? MAX_COLUMNS : COL_STATE_LIMIT;
  localparam int ROW_LIM =
    (MAX_TEXT_ROWS < ROW_STATE_LIMIT) ? MAX_TEXT_ROWS : ROW_STATE_LIMIT;
  localparam int GLYPH_LIMIT = FONT_BYTES / GLYPH_HEIGHT;

  logic [8:0]  columns_q;
  logic [7:0]  rows_q;
  logic [31:0] fore_q, back_q;
  logic [7:0]  col_q, col_d;
  logic [6:0]  row_q, row_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q <= COLUMNS_RESET;
      rows_q    <= ROWS_RESET;
      fore_q    <= FORE_RESET;
      back_q    <= BACK_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_COLUMNS:    columns_q <= cfg_data_i[8:0];
        CFG_ROWS:       rows_q    <= cfg_data_i[7:0];
        CFG_FORE_COLOR: fore_q    <= cfg_data_i;
        CFG_BACK_COLOR: back_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  always_comb begin
    logic [8:0] ncols;
    logic [7:0] nrows;
    logic [7:0] col;
    logic [6:0] row;
    logic [8:0] col_next;
    logic [7:0] row_next;
    logic       wrap;
    logic       draw;
    logic       scroll;
    logic [7:0] glyph;
    result_t    draw_r;
    result_t    scroll_r;

    // Zero counts as one, oversized values saturate to COL_LIM and ROW_LIM.
    if (columns_q == 9'd0) ncols = 9'd1;
    else if (columns_q > 9'(COL_LIM)) ncols = 9'(COL_LIM);
    else ncols = columns_q;
    if (rows_q == 8'd0) nrows = 8'd1;
    else if (rows_q > 8'(ROW_LIM)) nrows = 8'(ROW_LIM);
    else nrows = rows_q;

    // A cursor left outside a shrunken screen is pulled back first.
    col = ({1'b0, col_q} >= ncols) ? 8'(ncols - 9'd1) : col_q;
    row = ({1'b0, row_q} >= nrows) ? 7'(nrows - 8'd1) : row_q;

    draw     = 1'b0;
    wrap     = 1'b0;
    col_next = {1'b0, col};
    case (char_byte_i)
      CHAR_LF:  wrap = 1'b1;
      CHAR_CR:  col_next = 9'd0;
      CHAR_TAB: begin
        col_next = ({1'b0, col} + TAB_STEP) & ~(TAB_STEP - 9'd1);
        wrap     = (col_next >= ncols);
      end
      default: begin
        draw     = 1'b1;
        col_next = {1'b0, col} + 9'd1;
        wrap     = (col_next >= ncols);
      end
    endcase

    row_next = {1'b0, row} + 8'd1;
    scroll   = wrap && (row_next >= nrows);
    if (wrap) begin
      col_d = '0;
      row_d = scroll ? 7'(nrows - 8'd1) : row_next[6:0];
    end else begin
      col_d = col_next[7:0];
      row_d = row;
    end

    glyph = ({5'd0, char_byte_i} >= 13'(GLYPH_LIMIT)) ? GLYPH_UNKNOWN : char_byte_i;

    draw_r.command     = CMD_DRAW;
    draw_r.glyph_code  = glyph;
    draw_r.cell_column = col;
    draw_r.cell_row    = row;
    draw_r.ink_color   = fore_q;
    draw_r.paper_color = back_q;
    draw_r.last        = !scroll;

    scroll_r.command     = CMD_SCROLL;
    scroll_r.glyph_code  = '0;
    scroll_r.cell_column = '0;
    scroll_r.cell_row    = '0;
    scroll_r.ink_color   = fore_q;
    scroll_r.paper_color = back_q;
    scroll_r.last        = 1'b1;

    push_o.count  = {1'b0, draw} + {1'b0, scroll};
    push_o.first  = draw ? draw_r : scroll_r;
    push_o.second = scroll_r;
    if (!accept_i) push_o.count = 2'd0;
  end

endmodule

### hdl/tccc_queue.sv
module tccc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tccc_pkg::push_t   push_i,
  output logic              room_o,
  output logic              valid_o,
  input  logic              ready_i,
  output tccc_pkg::result_t head_o
);
  import tccc_pkg::*;

  result_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_q, rptr_q;
  logic [QCNT_W-1:0]   count_q, count_d;
  logic                pop;

  assign valid_o = (count_q != '0);
  assign pop     = valid_o && ready_i;
  // Room for the two entries a single byte can produce.
  assign room_o  = (count_q <= QCNT_W'(QUEUE_DEPTH - 2));
  assign head_o  = mem_q[rptr_q];

  assign count_d = count_q + QCNT_W'(push_i.count) - QCNT_W'(pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + QPTR_W'(push_i.count);
      rptr_q  <= rptr_q + QPTR_W'(pop);
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) mem_q[wptr_q] <= push_i.first;
    if (push_i.count == 2'd2) mem_q[wptr_q + QPTR_W'(1)] <= push_i.second;
  end

endmodule

### hdl/text_console_cursor_controller.sv
// Text console cursor controller.
// Input stream: one character byte per transaction on s_axis. Line feed,
// carriage return and tab move the cursor; other bytes become draw commands.
// Output stream: commands on m_axis; tuser is 0 for draw, 1 for scroll up,
// and tlast marks the final command caused by a byte. A byte causes zero,
// one or two commands (a draw followed by a scroll at most).
// Accepted bytes' commands are registered in the queue and offered in order.
// Throughput: one byte per cycle while each byte causes at most one command
// and the receiver takes every command; the output side moves one command
// per cycle, so two-command bytes hold the input back. The four-entry
// result queue sets this: s_axis_tready is high while at least two
// entries are free. When the receiver stalls, queued commands hold and the
// input is taken until the queue runs out of room.
// Reset clears the cursor to column 0, row 0, empties the queue and loads
// 128 columns, 48 rows, white ink and black paper.
// The configuration port writes one register per cycle with cfg_we_i; write
// it only while no commands are pending.
module text_console_cursor_controller #(
  parameter int MAX_COLUMNS   = tccc_pkg::DEF_MAX_COLUMNS,
  parameter int MAX_TEXT_ROWS = tccc_pkg::DEF_MAX_TEXT_ROWS,
  parameter int GLYPH_HEIGHT  = tccc_pkg::DEF_GLYPH_HEIGHT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tccc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [tccc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // Fields from bit 0: char_byte[7:0].
  input  logic [tccc_pkg::TDATA_IN_W-1:0]  s_axis_tdata,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // Fields from bit 0: glyph_code[7:0], cell_column[15:8], cell_row[22:16],
  // ink_color[54:23], paper_color[86:55], zero fill[87].
  output logic [tccc_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  // Fields from bit 0: command.
  output logic                              m_axis_tuser,
  output logic                              m_axis_tlast
);
  import tccc_pkg::*;

  logic    accept;
  push_t   push;
  result_t head;

  assign accept = s_axis_tvalid && s_axis_tready;

  tccc_cursor #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_TEXT_ROWS(MAX_TEXT_ROWS),
    .GLYPH_HEIGHT (GLYPH_HEIGHT)
  ) u_cursor (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .char_byte_i(s_axis_tdata[7:0]),
    .push_o     (push)
  );

  tccc_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (s_axis_tready),
    .valid_o(m_axis_tvalid),
    .ready_i(m_axis_tready),
    .head_o (head)
  );

  assign m_axis_tdata = {1'b0, head.paper_color, head.ink_color, head.cell_row,
                         head.cell_column, head.glyph_code};
  assign m_axis_tuser = head.command;
  assign m_axis_tlast = head.last;

endmodule

### hdl/tccc_checker.sv
`include "text_console_cursor_controller_defines.svh"

module tccc_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [tccc_pkg::TDATA_OUT_W-1:0] m_axis_tdata,
  input logic                              m_axis_tuser,
  input logic                              m_axis_tlast
);
  import tccc_pkg::*;

  // A stalled command stays offered and unchanged.
  `TCCC_ASSERT_NXT(a_stall_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))

  // A scroll carries no glyph and no cell position.
  `TCCC_ASSERT_IMP(a_scroll_zero, m_axis_tvalid && m_axis_tuser, m_axis_tdata[22:0] == 23'd0)

  // A scroll is always the final command of its byte.
  `TCCC_ASSERT_IMP(a_scroll_last, m_axis_tvalid && m_axis_tuser, m_axis_tlast)

endmodule

bind text_console_cursor_controller tccc_checker u_tccc_checker (.*);

### bench/text_console_cursor_controller_tb.sv
`timescale 1ns / 100ps

module text_console_cursor_controller_tb;
  import tccc_pkg::*;

  localparam int LIMIT_CYCLES  = 400000;
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 150;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 300;
  localparam int COL_CAP       = (DEF_MAX_COLUMNS < COL_STATE_LIMIT) ?
                                 DEF_MAX_COLUMNS : COL_STATE_LIMIT;
  localparam int ROW_CAP       = (DEF_MAX_TEXT_ROWS < ROW_STATE_LIMIT) ?
                                 DEF_MAX_TEXT_ROWS : ROW_STATE_LIMIT;
  localparam int GLYPH_COUNT   = FONT_BYTES / DEF_GLYPH_HEIGHT;

  // Tracks the cursor and screen registers and queues the commands each byte should produce.
  class cursor_scoreboard;
    logic [8:0]  columns;
    logic [7:0]  rows;
    logic [31:0] ink;
    logic [31:0] paper;
    int          cur_col;
    int          cur_row;
    result_t     step_cmds[$];
    result_t     expected_cmds[$];
    int          checked;
    int          scrolls;
    int          mismatches;

    function new();
      columns = COLUMNS_RESET;
      rows = ROWS_RESET;
      ink = FORE_RESET;
      paper = BACK_RESET;
      cur_col = 0;
      cur_row = 0;
      checked = 0;
      scrolls = 0;
      mismatches = 0;
    endfunction

    function void set_reg(cfg_idx_e idx, logic [31:0] value);
      case (idx)
        CFG_COLUMNS:    columns = value[8:0];
        CFG_ROWS:       rows = value[7:0];
        CFG_FORE_COLOR: ink = value;
        CFG_BACK_COLOR: paper = value;
        default: ;
      endcase
    endfunction

    function void push_command(cmd_e cmd, logic [7:0] glyph, int col, int row);
      result_t r;
      r.command = cmd;
      r.glyph_code = glyph;
      r.cell_column = col[7:0];
      r.cell_row = row[6:0];
      r.ink_color = ink;
      r.paper_color = paper;
      r.last = 1'b0;
      step_cmds.push_back(r);
    endfunction

    function void new_line(int nrows);
      cur_col = 0;
      cur_row++;
      if (cur_row >= nrows) begin
        push_command(CMD_SCROLL, 8'd0, 0, 0);
        cur_row = nrows - 1;
      end
    endfunction

    // Called for every accepted byte.
    function void note_char(logic [7:0] ch);
      int ncols;
      int nrows;
      logic [7:0] glyph;
      ncols = (columns == 0) ? 1 : ((int'(columns) > COL_CAP) ? COL_CAP : int'(columns));
      nrows = (rows == 0) ? 1 : ((int'(rows) > ROW_CAP) ? ROW_CAP : int'(rows));
      step_cmds.delete();
      // A cursor left outside a shrunken screen is pulled back first.
      if (cur_col >= ncols) cur_col = ncols - 1;
      if (cur_row >= nrows) cur_row = nrows - 1;
      if (ch == CHAR_LF) begin
        new_line(nrows);
      end else if (ch == CHAR_CR) begin
        cur_col = 0;
      end else if (ch == CHAR_TAB) begin
        cur_col = (cur_col + int'(TAB_STEP)) & ~(int'(TAB_STEP) - 1);
        if (cur_col >= ncols) new_line(nrows);
      end else begin
        glyph = (int'(ch) >= GLYPH_COUNT) ? GLYPH_UNKNOWN : ch;
        push_command(CMD_DRAW, glyph, cur_col, cur_row);
        cur_col++;
        if (cur_col >= ncols) new_line(nrows);
      end
      if (step_cmds.size() > 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
      foreach (step_cmds[i]) expected_cmds.push_back(step_cmds[i]);
    endfunction

    function void check_command(result_t got);
      result_t want;
      checked++;
      if (got.command == CMD_SCROLL) scrolls++;
      if (expected_cmds.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected command cmd=%0d glyph=%0d col=%0d row=%0d last=%0d",
                   $realtime, got.command, got.glyph_code, got.cell_column, got.cell_row,
                   got.last);
        return;
      end
      want = expected_cmds.pop_front();
      if (got.command !== want.command || got.glyph_code !== want.glyph_code ||
          got.cell_column !== want.cell_column || got.cell_row !== want.cell_row ||
          got.ink_color !== want.ink_color || got.paper_color !== want.paper_color ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("%0t: expected cmd=%0d glyph=%0d col=%0d row=%0d ink=%h paper=%h last=%0d",
                   $realtime, want.command, want.glyph_code, want.cell_column,
                   want.cell_row, want.ink_color, want.paper_color, want.last);
          $display("%0t:      got cmd=%0d glyph=%0d col=%0d row=%0d ink=%h paper=%h last=%0d",
                   $realtime, got.command, got.glyph_code, got.cell_column,
                   got.cell_row, got.ink_color, got.paper_color, got.last);
        end
      end
    endfunction
  endclass

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]   cfg_data_i = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [TDATA_IN_W-1:0]   s_axis_tdata = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [TDATA_OUT_W-1:0]  m_axis_tdata;
  logic                    m_axis_tuser;
  logic                    m_axis_tlast;

  cursor_scoreboard sb;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int input_stalls = 0;
  int bytes_sent = 0;
  int settings_used = 1;

  text_console_cursor_controller dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (s_axis_tvalid && !s_axis_tready && rst_ni) input_stalls++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles with %0d commands outstanding.",
               cycle_count, sb.expected_cmds.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Command receiver: checks each transaction and applies stalls and the long hold-off.
  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.command = cmd_e'(m_axis_tuser);
      got.glyph_code = m_axis_tdata[7:0];
      got.cell_column = m_axis_tdata[15:8];
      got.cell_row = m_axis_tdata[22:16];
      got.ink_color = m_axis_tdata[54:23];
      got.paper_color = m_axis_tdata[86:55];
      got.last = m_axis_tlast;
      sb.check_command(got);
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_char(logic [7:0] ch);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_char(ch);
    bytes_sent++;
  endtask

  // Drops valid, waits for every queued command, then lets in-flight bytes settle.
  task automatic settle_idle();
    s_axis_tvalid <= 1'b0;
    while (sb.expected_cmds.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_settings(logic [8:0] cols, logic [7:0] rws, logic [31:0] fg,
                                logic [31:0] bg);
    cfg_idx_e    idx [4];
    logic [31:0] val [4];
    idx = '{CFG_COLUMNS, CFG_ROWS, CFG_FORE_COLOR, CFG_BACK_COLOR};
    val = '{{23'd0, cols}, {24'd0, rws}, fg, bg};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i <= val[i];
      @(posedge clk_i);
      sb.set_reg(idx[i], val[i]);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Control bytes and out-of-font codes are weighted up; the rest is uniform.
  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(99);
    if (r < 10) return CHAR_LF;
    if (r < 15) return CHAR_CR;
    if (r < 25) return CHAR_TAB;
    if (r < 35) return 8'($urandom_range(255, GLYPH_COUNT));
    return 8'($urandom_range(255));
  endfunction

  initial begin
    logic [7:0]  script[$];
    logic [8:0]  cols;
    logic [7:0]  rws;
    logic [31:0] fg;
    logic [31:0] bg;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset screen: code extremes, the font boundary and each control byte.
    script = '{8'd0, 8'd255, 8'd243, 8'd244, 8'd65, CHAR_TAB, CHAR_CR, CHAR_LF, 8'd127, 8'd128};
    foreach (script[i]) send_char(script[i]);
    settle_idle();

    // A 5x2 screen forces wraps and scrolls.
    write_settings(9'd5, 8'd2, 32'hFFFF_FFFF, 32'h0000_0000);
    script = '{CHAR_TAB, 8'd120, CHAR_TAB, CHAR_LF, 8'd97, 8'd98, 8'd99, 8'd100, 8'd101,
               CHAR_CR, 8'd122, CHAR_TAB, 8'd113, CHAR_LF};
    foreach (script[i]) send_char(script[i]);
    settle_idle();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin cols = 9'd0;   rws = 8'd0;   end
        1: begin cols = 9'd1;   rws = 8'd1;   end
        2: begin cols = 9'd511; rws = 8'd255; end
        3: begin cols = 9'd256; rws = 8'd128; end
        default: begin
          cols = ($urandom_range(3) == 0) ? 9'($urandom_range(511)) : 9'($urandom_range(12, 1));
          rws = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(6, 1));
        end
      endcase
      fg = (p == 0) ? 32'h0000_0000 : (p == 1) ? 32'hFFFF_FFFF : $urandom;
      bg = (p == 0) ? 32'hFFFF_FFFF : (p == 1) ? 32'h0000_0000 : $urandom;
      write_settings(cols, rws, fg, bg);

      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      // One phase parks the receiver while bytes keep coming, so the queue fills.
      if (p == 4) hold_left = HOLD_CYCLES;

      for (int i = 0; i < PHASE_ITEMS; i++) send_char(pick_char());
      settle_idle();
      send_idle_pct = 0;
      recv_stall_pct = 0;
    end

    settle_idle();
    $display("Sent %0d bytes over %0d screen settings; %0d commands checked, %0d of them scrolls.",
             bytes_sent, settings_used, sb.checked, sb.scrolls);
    $display("Input was held back in %0d cycles; %0d mismatches in total.",
             input_stalls, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_cmds.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+hdl
hdl/tccc_pkg.sv
hdl/tccc_cursor.sv
hdl/tccc_queue.sv
hdl/text_console_cursor_controller.sv
hdl/tccc_checker.sv
bench/text_console_cursor_controller_tb.sv
